FILE: rtl/core/ddo_pkg.sv
// Package for the differential drive odometry block.
// Holds the word types, CORDIC constants and the arctangent table.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } ddo_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading_out;
  } ddo_out_t;

  typedef struct packed {
    logic load;
    logic turn;
    logic head;
    logic rot;
    logic fin;
    logic mul;
    logic acc;
  } ddo_cmd_t;

  localparam logic [31:0] TURN_SCALE_RESET = 32'd68356529;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] UNIT_Q30 = 34'sd1073741824;
  localparam logic signed [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] POS_MIN = {1'b1, {47{1'b0}}};

  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;
      5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;
      5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;
      5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/differential_drive_odometry.sv
// Differential drive odometry top level: controller, datapath, turn scale.
// An accepted word steps through turn, heading, CORDIC rotation, finish, multiply and
// accumulate to the result; the next word is accepted only after the result is taken.
// Reset (rst_n, synchronous) zeroes counts, heading and position; turn scale
// returns to 68356529. Depends on ddo_pkg, ddo_ctrl and ddo_datapath.
`timescale 1ns / 1ps
`default_nettype none
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire ddo_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ddo_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] turn_scale_r;
  ddo_cmd_t cmd;
  logic [4:0] step_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) turn_scale_r <= TURN_SCALE_RESET;
    else if (cfg_valid) turn_scale_r <= cfg_data;
  end

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .step_idx
  );

  ddo_datapath u_dp (
    .clk, .rst_n, .cmd, .step_idx, .in_word(in_data), .turn_scale(turn_scale_r),
    .result(out_data)
  );

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and result both up");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second word taken");

endmodule
`default_nettype wire

FILE: rtl/core/ddo_datapath.sv
// Datapath of the odometry block: deltas, heading, CORDIC rotation and
// position accumulation. Depends on ddo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddo_datapath import ddo_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ddo_cmd_t    cmd,
  input  wire logic [4:0]  step_idx,
  input  wire ddo_in_t     in_word,
  input  wire logic [31:0] turn_scale,
  output ddo_out_t         result
);

  logic [31:0] prev_left_r, prev_right_r, heading_r;
  logic signed [47:0] x_acc_r, y_acc_r;
  logic signed [32:0] diff_r;
  logic signed [33:0] sum_r;
  logic [31:0] turn_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic signed [67:0] px_r, py_r;

  logic signed [32:0] dl, dr;
  logic [31:0] head_nxt, ang;
  logic signed [33:0] sh_x, sh_y, cl_x, cl_y;
  logic signed [49:0] stx, sty;
  logic signed [49:0] sx, sy;

  assign dl = 33'(in_word.left_count) - 33'($signed(prev_left_r));
  assign dr = 33'(in_word.right_count) - 33'($signed(prev_right_r));
  assign head_nxt = heading_r + turn_r;
  assign ang = head_nxt ^ {((head_nxt + 32'h4000_0000) >> 31) != 32'd0, 31'd0};
  assign sh_x = cx_r >>> step_idx;
  assign sh_y = cy_r >>> step_idx;

  function automatic logic signed [33:0] clampu(input logic signed [33:0] v,
                                                input logic f);
    logic signed [33:0] c;
    c = (v > UNIT_Q30) ? UNIT_Q30 : ((v < -UNIT_Q30) ? -UNIT_Q30 : v);
    return f ? -c : c;
  endfunction

  assign cl_x = clampu(cx_r, flip_r);
  assign cl_y = clampu(cy_r, flip_r);
  assign stx = 50'((px_r + 68'sd16384) >>> 15);
  assign sty = 50'((py_r + 68'sd16384) >>> 15);
  assign sx = 50'(x_acc_r) + stx;
  assign sy = 50'(y_acc_r) + sty;

  function automatic logic signed [47:0] sat(input logic signed [49:0] v);
    if (v > 50'(POS_MAX)) return POS_MAX;
    if (v < 50'(POS_MIN)) return POS_MIN;
    return v[47:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r <= '0;
      prev_right_r <= '0;
      heading_r <= '0;
      x_acc_r <= '0;
      y_acc_r <= '0;
    end else begin
      if (cmd.load) begin
        diff_r <= dl - dr;
        sum_r <= 34'(dl) + 34'(dr);
        prev_left_r <= in_word.left_count;
        prev_right_r <= in_word.right_count;
      end
      if (cmd.turn) begin
        turn_r <= diff_r[31:0] * turn_scale;
      end
      if (cmd.head) begin
        heading_r <= head_nxt;
        flip_r <= ang != head_nxt;
        cx_r <= CORDIC_GAIN;
        cy_r <= '0;
        cz_r <= 34'($signed(ang));
      end
      if (cmd.rot) begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - sh_y;
          cy_r <= cy_r + sh_x;
          cz_r <= cz_r - atan_lut(step_idx);
        end else begin
          cx_r <= cx_r + sh_y;
          cy_r <= cy_r - sh_x;
          cz_r <= cz_r + atan_lut(step_idx);
        end
      end
      if (cmd.fin) begin
        cx_r <= cl_x;
        cy_r <= cl_y;
      end
      if (cmd.mul) begin
        px_r <= sum_r * cx_r;
        py_r <= sum_r * cy_r;
      end
      if (cmd.acc) begin
        x_acc_r <= sat(sx);
        y_acc_r <= sat(sy);
      end
    end
  end

  assign result.pos_x = x_acc_r;
  assign result.pos_y = y_acc_r;
  assign result.heading_out = heading_r;

endmodule
`default_nettype wire

FILE: rtl/core/ddo_ctrl.sv
// Sequencer of the odometry block: steps one word through load, turn, heading,
// CORDIC iterations, finish, multiply, accumulate and output. Depends on ddo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddo_ctrl import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ddo_cmd_t        cmd,
  output logic [4:0]      step_idx
);

  localparam logic [2:0] S_IDLE = 3'd0, S_TURN = 3'd1, S_HEAD = 3'd2, S_ROT = 3'd3,
                         S_FIN = 3'd4, S_MUL = 3'd5, S_ACC = 3'd6, S_OUT = 3'd7;
  localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign step_idx = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_TURN;
      end
      S_TURN: begin
        cmd.turn = 1'b1;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.head = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: verif/differential_drive_odometry_tb.sv
// Self-checking testbench for differential_drive_odometry: drives encoder count words,
// predicts x, y and heading with its own fixed-point CORDIC model, and compares results.
// Depends on ddo_pkg and the differential_drive_odometry RTL.
`timescale 1ns / 1ps
module differential_drive_odometry_tb;
  import ddo_pkg::*;

  localparam int unsigned STEPS = 24;
  localparam int unsigned LATENCY = STEPS + 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ddo_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ddo_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  differential_drive_odometry #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] model_scale;
  logic [31:0] model_prev_left;
  logic [31:0] model_prev_right;
  logic [31:0] model_heading;
  longint model_x;
  longint model_y;
  ddo_out_t pose_queue[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_out = 1'b0;

  typedef struct {
    logic [31:0] left;
    logic [31:0] right;
    bit          typed;
    ddo_out_t    pose;
  } row_t;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > 64'sd140737488355327) return 64'sd140737488355327;
    if (v < -64'sd140737488355328) return -64'sd140737488355328;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                      10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  task automatic sine_cosine(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] a;
    logic [31:0] probe;
    bit flip;
    longint x;
    longint y;
    longint z;
    longint nx;
    a = ang;
    probe = a + 32'h4000_0000;
    flip = probe[31];
    if (flip) a = a ^ 32'h8000_0000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - atan_entry(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + atan_entry(i);
      end
      x = nx;
    end
    x = clamp_unit(x);
    y = clamp_unit(y);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic advance_pose(input logic [31:0] left, input logic [31:0] right,
                              output ddo_out_t pose);
    longint dl;
    longint dr;
    longint sum;
    longint c;
    longint s;
    logic [63:0] turn;
    dl = longint'($signed(left)) - longint'($signed(model_prev_left));
    dr = longint'($signed(right)) - longint'($signed(model_prev_right));
    sum = dl + dr;
    turn = 64'(dl - dr) * 64'(model_scale);
    model_heading = model_heading + turn[31:0];
    sine_cosine(model_heading, c, s);
    model_x = sat_pos(model_x + floor_shift(sum * c + 16384, 15));
    model_y = sat_pos(model_y + floor_shift(sum * s + 16384, 15));
    model_prev_left = left;
    model_prev_right = right;
    pose.pos_x = model_x[47:0];
    pose.pos_y = model_y[47:0];
    pose.heading_out = model_heading;
  endtask

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_pose_word(input logic [31:0] left, input logic [31:0] right);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    in_data.left_count = left;
    in_data.right_count = right;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_scale(input logic [31:0] value);
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    model_scale = value;
  endtask

  task automatic drive_predicted(input logic [31:0] left, input logic [31:0] right);
    ddo_out_t pose;
    advance_pose(left, right, pose);
    pose_queue.push_back(pose);
    send_pose_word(left, right);
  endtask

  function automatic logic [31:0] random_step(input logic [31:0] prev, input int span);
    return prev + 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  always @(posedge clk) begin
    ddo_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        want = pose_queue.pop_front();
        if (out_data.pos_x !== want.pos_x) report_mismatch("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y !== want.pos_y) report_mismatch("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.heading_out !== want.heading_out)
          report_mismatch("heading_out", 48'(out_data.heading_out), 48'(want.heading_out));
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #50ms;
    $display("differential_drive_odometry verification failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    ddo_out_t pose;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] scales[6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h4000_0000, 32'd12345, 32'd68356529};
    model_scale = TURN_SCALE_RESET;
    model_prev_left = '0;
    model_prev_right = '0;
    model_heading = '0;
    model_x = 0;
    model_y = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows.push_back('{32'd0, 32'd0, 1'b1, '{48'd0, 48'd0, 32'd0}});
    rows.push_back('{32'd100, 32'd100, 1'b0, '0});
    rows.push_back('{32'd200, 32'd100, 1'b0, '0});
    rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0, '0});
    rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0});
    rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0});
    rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0, '0});
    for (int i = 0; i < 8; i++) rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0});
    for (int i = 0; i < 8; i++) rows.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0});
    foreach (rows[i]) begin
      advance_pose(rows[i].left, rows[i].right, pose);
      pose_queue.push_back(rows[i].typed ? rows[i].pose : pose);
      send_pose_word(rows[i].left, rows[i].right);
    end

    l = model_prev_left;
    r = model_prev_right;
    for (int p = 0; p < 6; p++) begin
      write_scale(scales[p]);
      if (p == 2) begin
        hold_out = 1'b1;
        fork
          begin
            repeat (400) @(negedge clk);
            hold_out = 1'b0;
          end
          for (int k = 0; k < 10; k++) begin
            l = random_step(l, 5000);
            r = random_step(r, 5000);
            drive_predicted(l, r);
          end
        join
      end
      for (int k = 0; k < 150; k++) begin
        if (p == 5 && k == 100) quiet = 1'b1;
        case ($urandom_range(0, 9))
          0: begin
            l = $urandom;
            r = $urandom;
          end
          1: begin
            l = random_step(l, 100000);
            r = l + 32'($urandom_range(0, 3)) - 32'd1;
          end
          default: begin
            l = random_step(l, 2000);
            r = random_step(r, 2000);
          end
        endcase
        drive_predicted(l, r);
      end
    end

    while (pose_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) begin
      $display("differential_drive_odometry verification clean");
    end else begin
      $display("differential_drive_odometry verification failed");
    end
    $finish;
  end
endmodule
